FILE: rtl/bpe_pkg.sv
// Shared constants, register indexes and types of the Bezier point evaluator.
`default_nettype none

package bpe_pkg;

    localparam int CoordWidth  = 16;
    localparam int TFracBits   = 16;
    localparam int TWidth      = TFracBits + 1;
    localparam int NumPoints   = 4;
    localparam int NumCoords   = 3;
    localparam int PointWidth  = NumCoords * CoordWidth;
    localparam int CfgIdxWidth = 3;
    localparam int TriWidth    = TWidth + 2;
    localparam int ProdWidth   = TWidth + CoordWidth;
    localparam int AccWidth    = ProdWidth + 2;
    localparam int RoundWidth  = AccWidth - TFracBits;

    localparam logic [TWidth-1:0]     TOne      = {1'b1, {TFracBits{1'b0}}};
    localparam logic [CoordWidth-1:0] CoordBias = {1'b1, {(CoordWidth - 1){1'b0}}};
    localparam logic [AccWidth-1:0]   RoundHalf = {{(AccWidth - TFracBits){1'b0}},
                                                   1'b1, {(TFracBits - 1){1'b0}}};

    // Configuration register indexes
    localparam logic [CfgIdxWidth-1:0] RegPoint0   = 3'd0;
    localparam logic [CfgIdxWidth-1:0] RegPoint1   = 3'd1;
    localparam logic [CfgIdxWidth-1:0] RegPoint2   = 3'd2;
    localparam logic [CfgIdxWidth-1:0] RegPoint3   = 3'd3;
    localparam logic [CfgIdxWidth-1:0] RegQuadMode = 3'd4;

    typedef logic [TWidth-1:0]                    weight_t;
    typedef weight_t [NumPoints-1:0]              weight_vec_t;
    typedef logic [CoordWidth-1:0]                coord_t;
    typedef coord_t [NumCoords-1:0]               coord_vec_t;
    typedef logic [NumPoints-1:0][PointWidth-1:0] point_vec_t;

    typedef struct packed {
        point_vec_t point;
        logic       quad_mode;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        weight_vec_t weight;
    } wt_beat_t;

endpackage

`default_nettype wire

FILE: rtl/bpe_param_if.sv
// Input channel: one curve parameter per beat.
`default_nettype none

interface bpe_param_if;
    logic                         valid;
    logic                         ready;
    logic [bpe_pkg::TWidth-1:0]   t_param;

    modport source (output valid, output t_param, input ready);
    modport sink   (input valid, input t_param, output ready);
endinterface

`default_nettype wire

FILE: rtl/bpe_point_if.sv
// Output channel: one curve point per beat.
`default_nettype none

interface bpe_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [bpe_pkg::CoordWidth-1:0] x_out;
    logic signed [bpe_pkg::CoordWidth-1:0] y_out;
    logic signed [bpe_pkg::CoordWidth-1:0] z_out;

    modport source (output valid, output x_out, output y_out, output z_out, input ready);
    modport sink   (input valid, input x_out, input y_out, input z_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/bpe_cfg_regs.sv
// Control point and mode registers behind the configuration write port.
`default_nettype none

module bpe_cfg_regs
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [bpe_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  wire logic [bpe_pkg::PointWidth-1:0]    cfg_data,
    output bpe_pkg::cfg_t                          cfg
);

    bpe_pkg::point_vec_t point_reg;
    bpe_pkg::point_vec_t point_next;
    logic                quad_mode_reg;
    logic                quad_mode_next;

    always_comb
    begin
        point_next     = point_reg;
        quad_mode_next = quad_mode_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                bpe_pkg::RegPoint0:   point_next[0]  = cfg_data;
                bpe_pkg::RegPoint1:   point_next[1]  = cfg_data;
                bpe_pkg::RegPoint2:   point_next[2]  = cfg_data;
                bpe_pkg::RegPoint3:   point_next[3]  = cfg_data;
                bpe_pkg::RegQuadMode: quad_mode_next = cfg_data[0];
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_reg     <= '0;
            quad_mode_reg <= 1'b1;
        end
        else
        begin
            point_reg     <= point_next;
            quad_mode_reg <= quad_mode_next;
        end
    end

    assign cfg.point     = point_reg;
    assign cfg.quad_mode = quad_mode_reg;

endmodule

`default_nettype wire

FILE: rtl/bpe_weight_pipe.sv
// Four-stage Bernstein weight pipeline: clamp t, square, cube, close the sum to one.
`default_nettype none

module bpe_weight_pipe
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic                          in_valid,
    input  wire logic [bpe_pkg::TWidth-1:0]    t_param,
    input  wire logic                          quad_mode,
    output bpe_pkg::wt_beat_t                  beat
);

    localparam int TW  = bpe_pkg::TWidth;
    localparam int TF  = bpe_pkg::TFracBits;
    localparam int TRW = bpe_pkg::TriWidth;

    logic [4:1] v_reg;

    // stage 1
    logic [TW-1:0] t1_reg, u1_reg, t1_next, u1_next;
    // stage 2
    logic [TW-1:0]   t2_reg, u2_reg, uu2_reg, tt2_reg, ut2_reg;
    logic [2*TW-1:0] prod_uu, prod_tt, prod_ut;
    // stage 3
    logic [TRW-1:0]      uu3, u3;
    logic [2*TW-1:0]     prod_c0;
    logic [TRW+TW-1:0]   prod_c1, prod_c2;
    logic [TW-1:0]       w0_3_reg, w1_3_reg, w2_3_reg;
    logic [TW-1:0]       w0_3_next, w1_3_next, w2_3_next;
    // stage 4
    logic [TW-1:0]         w_last;
    bpe_pkg::weight_vec_t  w4_reg, w4_next;

    always_comb
    begin
        t1_next = (t_param > bpe_pkg::TOne) ? bpe_pkg::TOne : t_param;
        u1_next = bpe_pkg::TOne - t1_next;
    end

    assign prod_uu = u1_reg * u1_reg;
    assign prod_tt = t1_reg * t1_reg;
    assign prod_ut = u1_reg * t1_reg;

    // 3*x as shift plus add ahead of the cubic products
    assign uu3     = {1'b0, uu2_reg, 1'b0} + {2'b00, uu2_reg};
    assign u3      = {1'b0, u2_reg, 1'b0} + {2'b00, u2_reg};
    assign prod_c0 = uu2_reg * u2_reg;
    assign prod_c1 = uu3 * t2_reg;
    assign prod_c2 = u3 * tt2_reg;

    always_comb
    begin
        if (quad_mode)
        begin
            w0_3_next = uu2_reg;
            w1_3_next = ut2_reg;
            w2_3_next = '0;
        end
        else
        begin
            w0_3_next = prod_c0[TF +: TW];
            w1_3_next = prod_c1[TF +: TW];
            w2_3_next = prod_c2[TF +: TW];
        end
    end

    // the closing weight takes whatever the truncated ones leave of one
    assign w_last = bpe_pkg::TOne - w0_3_reg - w1_3_reg - w2_3_reg;

    always_comb
    begin
        w4_next[0] = w0_3_reg;
        w4_next[1] = w1_3_reg;
        if (quad_mode)
        begin
            w4_next[2] = w_last;
            w4_next[3] = '0;
        end
        else
        begin
            w4_next[2] = w2_3_reg;
            w4_next[3] = w_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[3:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            t1_reg   <= t1_next;
            u1_reg   <= u1_next;
            t2_reg   <= t1_reg;
            u2_reg   <= u1_reg;
            uu2_reg  <= prod_uu[TF +: TW];
            tt2_reg  <= prod_tt[TF +: TW];
            ut2_reg  <= prod_ut[TF-1 +: TW];
            w0_3_reg <= w0_3_next;
            w1_3_reg <= w1_3_next;
            w2_3_reg <= w2_3_next;
            w4_reg   <= w4_next;
        end
    end

    assign beat.valid  = v_reg[4];
    assign beat.weight = w4_reg;

endmodule

`default_nettype wire

FILE: rtl/bpe_blend.sv
// Two-stage blend: weight times biased coordinate, then sum, round and unbias.
`default_nettype none

module bpe_blend
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  advance,
    input  wire bpe_pkg::wt_beat_t     beat,
    input  wire bpe_pkg::point_vec_t   point,
    output logic                       out_valid,
    output bpe_pkg::coord_vec_t        coord
);

    localparam int NP = bpe_pkg::NumPoints;
    localparam int NC = bpe_pkg::NumCoords;
    localparam int CW = bpe_pkg::CoordWidth;
    localparam int PW = bpe_pkg::ProdWidth;
    localparam int AW = bpe_pkg::AccWidth;
    localparam int RW = bpe_pkg::RoundWidth;
    localparam int TF = bpe_pkg::TFracBits;

    logic [1:0] v_reg;

    logic [NP-1:0][NC-1:0][PW-1:0] prod_reg, prod_next;
    bpe_pkg::coord_vec_t           coord_reg, coord_next;

    // stage 5: one product per point and axis, coordinates offset to unsigned
    always_comb
    begin
        for (int i = 0; i < NP; i++)
        begin
            for (int k = 0; k < NC; k++)
            begin
                prod_next[i][k] = beat.weight[i] *
                                  (point[i][k*CW +: CW] ^ bpe_pkg::CoordBias);
            end
        end
    end

    // stage 6: sum per axis, round half up, clamp, undo the offset
    always_comb
    begin
        logic [AW-1:0] acc;
        logic [RW-1:0] rounded;
        logic [CW-1:0] clamped;
        for (int k = 0; k < NC; k++)
        begin
            acc = bpe_pkg::RoundHalf;
            for (int i = 0; i < NP; i++)
            begin
                acc = acc + AW'(prod_reg[i][k]);
            end
            rounded = acc[AW-1:TF];
            clamped = (|rounded[RW-1:CW]) ? {CW{1'b1}} : rounded[CW-1:0];
            coord_next[k] = clamped ^ bpe_pkg::CoordBias;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[0], beat.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg  <= prod_next;
            coord_reg <= coord_next;
        end
    end

    assign out_valid = v_reg[1];
    assign coord     = coord_reg;

endmodule

`default_nettype wire

FILE: rtl/bezier_point_evaluator.sv
// Top level of the quadratic/cubic 3D Bezier point evaluator.
//
//   Channel    Dir  Handshake           Payload
//   ---------  ---  ------------------  ---------------------------------------
//   params     in   valid/ready         t_param  (17b unsigned, 16 frac bits)
//   points     out  valid/ready         x_out, y_out, z_out (16b signed each)
//   cfg_*      in   cfg_we, no ready    cfg_index (3b), cfg_data (48b)
//
// Throughput is one t per clock unless points stalls; an accepted t passes
// four weight stages, product and sum/round to reach the output register.
// All stages advance together whenever the output register is empty or being
// drained, so a stall on points freezes the whole pipe: nothing is lost or
// repeated, and bubbles stay in place. Reset clears the stage valid bits and
// loads the control points with zero and the mode with quadratic.
`default_nettype none

module bezier_point_evaluator
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [bpe_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  wire logic [bpe_pkg::PointWidth-1:0]    cfg_data,
    bpe_param_if.sink                              params,
    bpe_point_if.source                            points
);

    bpe_pkg::cfg_t       cfg;
    bpe_pkg::wt_beat_t   wt_beat;
    bpe_pkg::coord_vec_t coord;
    logic                out_valid;
    logic                advance;

    // Hold every stage while a finished point waits on a stalled sink;
    // otherwise advance, which also takes the next t.
    assign advance = !out_valid || points.ready;

    bpe_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Weights: clamp t to one, form u = 1 - t, then the Bernstein terms.
    // The mode register selects quadratic or cubic terms; the user must change it
    // only while the pipe is empty (the block does not enforce it); each stage reads it directly.
    bpe_weight_pipe u_weight_pipe
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (params.valid),
        .t_param   (params.t_param),
        .quad_mode (cfg.quad_mode),
        .beat      (wt_beat)
    );

    // Blend: weighted sum of offset coordinates, rounded half up.
    bpe_blend u_blend
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .beat      (wt_beat),
        .point     (cfg.point),
        .out_valid (out_valid),
        .coord     (coord)
    );

    assign params.ready = advance;
    assign points.valid = out_valid;
    assign points.x_out = $signed(coord[0]);
    assign points.y_out = $signed(coord[1]);
    assign points.z_out = $signed(coord[2]);

endmodule

`default_nettype wire

FILE: tb/bezier_point_evaluator_tb.sv
// Self-checking testbench of the Bezier point evaluator: directed and random t beats.
`default_nettype none

module bezier_point_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpe_pkg::*;

    // Pipe depth per the design header: weight stages, product and sum/round, t to point register.
    localparam int Latency        = 6;
    localparam int IdleLimit      = 4000;
    localparam int MaxReports     = 10;
    localparam int SinkHoldCycles = 300;
    localparam int PhaseItems     = 60;
    localparam int NumPhases      = 8;

    // Register indexes that decode to nothing; writes there must be dropped.
    localparam logic [CfgIdxWidth-1:0] RegSpare5 = 3'd5;
    localparam logic [CfgIdxWidth-1:0] RegSpare6 = 3'd6;
    localparam logic [CfgIdxWidth-1:0] RegSpare7 = 3'd7;

    localparam logic [TWidth-1:0]     THalf    = TOne >> 1;
    localparam logic [TWidth-1:0]     TAllOnes = '1;
    localparam logic [CoordWidth-1:0] CoordMin = CoordBias;
    localparam logic [CoordWidth-1:0] CoordMax = ~CoordBias;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } curve_point_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CfgIdxWidth-1:0] cfg_index;
    logic [PointWidth-1:0]  cfg_data;

    bpe_param_if params_ch ();
    bpe_point_if points_ch ();

    bezier_point_evaluator uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .params    (params_ch),
        .points    (points_ch)
    );

    // Shadow copy of the configuration, updated at the edge that writes it.
    logic [PointWidth-1:0] ctrl_pt [NumPoints];
    logic                  quad_sel;

    // Points still owed by the block, oldest first.
    curve_point_t pending_points [$];

    // Pacing controls shared by the sender, the receiver and the tests.
    bit pace_idle     = 1'b1;
    bit sink_hold_req = 1'b0;
    bit sink_holding  = 1'b0;

    int beats_sent    = 0;
    int points_seen   = 0;
    int mismatches    = 0;
    int orphan_points = 0;
    int curve_loads   = 0;
    int idle_cycles   = 0;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Point prediction. Weights are Bernstein terms truncated to the t grid,
    // the last one taking the remainder so they sum to exactly one. Coordinates
    // are offset to unsigned before weighting, then rounded half up and offset
    // back, which keeps the whole sum non-negative.
    // ------------------------------------------------------------------
    function automatic curve_point_t bezier_point(input logic [TWidth-1:0] t_raw);
        logic [63:0]           t;
        logic [63:0]           u;
        logic [63:0]           uu;
        logic [63:0]           tt;
        logic [63:0]           acc;
        logic [63:0]           rnd;
        logic [63:0]           wt [NumPoints];
        logic [CoordWidth-1:0] biased;
        coord_t                coord [NumCoords];
        curve_point_t          pt;
        int                    npts;
        t = (t_raw > TOne) ? 64'(TOne) : 64'(t_raw);     // clamp t above one
        u = 64'(TOne) - t;
        uu = (u * u) >> TFracBits;
        tt = (t * t) >> TFracBits;
        if (quad_sel)
        begin
            npts = 3;
            wt[0] = uu;
            wt[1] = (64'd2 * u * t) >> TFracBits;
            wt[2] = 64'(TOne) - wt[0] - wt[1];
            wt[3] = '0;
        end
        else
        begin
            npts = 4;
            wt[0] = (uu * u) >> TFracBits;
            wt[1] = (64'd3 * uu * t) >> TFracBits;
            wt[2] = (64'd3 * u * tt) >> TFracBits;
            wt[3] = 64'(TOne) - wt[0] - wt[1] - wt[2];
        end
        for (int k = 0; k < NumCoords; k++)
        begin
            acc = '0;
            for (int i = 0; i < npts; i++)
            begin
                biased = ctrl_pt[i][k*CoordWidth +: CoordWidth] ^ CoordBias;
                acc += wt[i] * 64'(biased);
            end
            rnd = (acc + 64'(THalf)) >> TFracBits;
            if (rnd > 64'(CoordMax ^ CoordBias))
                rnd = 64'(CoordMax ^ CoordBias);
            coord[k] = rnd[CoordWidth-1:0] ^ CoordBias;
        end
        pt.x = coord[0];
        pt.y = coord[1];
        pt.z = coord[2];
        return pt;
    endfunction

    // ------------------------------------------------------------------
    // Random draws
    // ------------------------------------------------------------------

    // Mostly short gaps, a few long ones; none while pacing is off.
    function automatic int pick_gap();
        int r;
        if (!pace_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Bias toward the endpoints, keep some beats above one and over all 17 bits.
    function automatic logic [TWidth-1:0] rand_t();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 10)
            return TOne;
        if (r < 20)
            return TWidth'($urandom());
        return TWidth'($urandom_range(0, int'(TOne)));
    endfunction

    function automatic coord_t rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return CoordMin;
        if (r < 16)
            return CoordMax;
        return coord_t'($urandom());
    endfunction

    function automatic logic [PointWidth-1:0] rand_point();
        return {rand_coord(), rand_coord(), rand_coord()};
    endfunction

    // ------------------------------------------------------------------
    // Configuration writes. Keep cfg_we high across back-to-back writes and
    // drop it one edge after the last.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                             input logic [PointWidth-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            RegPoint0, RegPoint1, RegPoint2, RegPoint3: ctrl_pt[idx] = data;
            RegQuadMode: quad_sel = data[0];
            default: ;
        endcase
    endtask

    task automatic load_curve(input logic [PointWidth-1:0] p0,
                              input logic [PointWidth-1:0] p1,
                              input logic [PointWidth-1:0] p2,
                              input logic [PointWidth-1:0] p3,
                              input logic [PointWidth-1:0] mode_word);
        write_reg(RegPoint0, p0);
        write_reg(RegPoint1, p1);
        write_reg(RegPoint2, p2);
        write_reg(RegPoint3, p3);
        write_reg(RegQuadMode, mode_word);
        cfg_we <= 1'b0;
        @(posedge clk);
        curve_loads++;
    endtask

    // Drop valid, wait for every owed point, then let the pipe run dry.
    task automatic settle_pipe();
        params_ch.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (Latency + 2) @(posedge clk);
    endtask

    // Offer one t and hold it until the block takes it. Valid stays high on
    // exit so a zero gap gives back-to-back beats.
    task automatic send_t(input logic [TWidth-1:0] t);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            params_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        params_ch.valid   <= 1'b1;
        params_ch.t_param <= t;
        @(posedge clk);
        while (!params_ch.ready)
            @(posedge clk);
        pending_points.push_back(bezier_point(t));
        beats_sent++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready runs, a free-running mode, and a long hold-off
    // on request.
    // ------------------------------------------------------------------
    initial
    begin
        int r;
        int run;
        points_ch.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (sink_hold_req)
            begin
                points_ch.ready <= 1'b0;
                sink_holding = 1'b1;
                repeat (SinkHoldCycles) @(posedge clk);
                sink_holding  = 1'b0;
                sink_hold_req = 1'b0;
            end
            else if (!pace_idle)
            begin
                points_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    points_ch.ready <= 1'b1;
                    run = $urandom_range(1, 20);
                end
                else if (r < 93)
                begin
                    points_ch.ready <= 1'b0;
                    run = $urandom_range(1, 3);
                end
                else
                begin
                    points_ch.ready <= 1'b0;
                    run = $urandom_range(10, 40);
                end
                repeat (run) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: compare each point beat against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        curve_point_t want;
        curve_point_t got;
        if (rst_n && points_ch.valid && points_ch.ready)
        begin
            got.x = points_ch.x_out;
            got.y = points_ch.y_out;
            got.z = points_ch.z_out;
            points_seen++;
            if (pending_points.size() == 0)
            begin
                orphan_points++;
                mismatches++;
                if (mismatches <= MaxReports)
                    $display("unexpected point beat: x=%0d y=%0d z=%0d",
                             $signed(got.x), $signed(got.y), $signed(got.z));
            end
            else
            begin
                want = pending_points.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.z !== want.z)
                begin
                    mismatches++;
                    if (mismatches <= MaxReports)
                        $display("point %0d mismatch (exp/got): x %0d/%0d y %0d/%0d z %0d/%0d",
                                 points_seen - 1,
                                 $signed(want.x), $signed(got.x),
                                 $signed(want.y), $signed(got.y),
                                 $signed(want.z), $signed(got.z));
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((params_ch.valid && params_ch.ready) || (points_ch.valid && points_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IdleLimit)
            begin
                $display("timeout: no beat for %0d cycles, %0d points owed",
                         IdleLimit, pending_points.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset state: all points zero and quadratic mode, so every t maps to the origin.
    task automatic test_reset_state();
        send_t(THalf);
        send_t(TAllOnes);
        settle_pipe();
    endtask

    // Endpoints and clamping: t = 0 lands on point 0, t = one (or anything
    // above it) on the end point; extreme coordinates in both modes.
    task automatic test_endpoints();
        logic [PointWidth-1:0] p_min;
        logic [PointWidth-1:0] p_max;
        logic [PointWidth-1:0] p_mix;
        logic [PointWidth-1:0] p_alt;
        p_min = {CoordMin, CoordMin, CoordMin};
        p_max = {CoordMax, CoordMax, CoordMax};
        p_mix = {16'sd1, CoordMin, CoordMax};
        p_alt = {CoordMin, CoordMax, 16'hFFFF};
        load_curve(p_min, p_max, p_mix, p_alt, PointWidth'(1));
        send_t('0);
        send_t(TOne);
        send_t(TOne + 1'b1);
        send_t(TAllOnes);
        send_t(TWidth'(1));
        send_t(THalf);
        settle_pipe();
        load_curve(p_mix, p_min, p_max, p_alt, PointWidth'(0));
        send_t('0);
        send_t(TOne);
        send_t(TOne + 1'b1);
        send_t(TAllOnes);
        send_t(TOne - 1'b1);
        send_t(THalf);
        settle_pipe();
    endtask

    // The fourth point must not leak into a quadratic curve but must steer a cubic one.
    task automatic test_unused_point();
        logic [PointWidth-1:0] p_far;
        p_far = {CoordMax, CoordMin, CoordMax};
        load_curve('0, '0, '0, p_far, PointWidth'(1));
        send_t(THalf);
        send_t(TOne);
        settle_pipe();
        load_curve('0, '0, '0, p_far, PointWidth'(0));
        send_t(THalf);
        send_t(TOne);
        settle_pipe();
    endtask

    // Exact halves: at t = 1/2 the middle quadratic weight is exactly one half,
    // so +1 rounds up to 1 and -1 rounds up to 0.
    task automatic test_half_rounding();
        load_curve('0, {CoordMin, 16'hFFFF, 16'h0001}, '0, rand_point(), PointWidth'(1));
        send_t(THalf);
        send_t(TWidth'(1));
        settle_pipe();
    endtask

    // Writes to undecoded indexes are dropped; the mode register uses bit 0 only.
    task automatic test_spare_index();
        load_curve(rand_point(), rand_point(), rand_point(), rand_point(),
                   {{(PointWidth - 1){1'b1}}, 1'b0});
        write_reg(RegSpare5, '1);
        write_reg(RegSpare6, rand_point());
        write_reg(RegSpare7, {(PointWidth / 2){2'b01}});
        cfg_we <= 1'b0;
        @(posedge clk);
        send_t(THalf);
        send_t(rand_t());
        settle_pipe();
    endtask

    // Random curves in phases: extremes first, then random points and mode;
    // one phase runs with no idling on either side.
    task automatic test_random_curves();
        logic [PointWidth-1:0] p_min;
        logic [PointWidth-1:0] p_max;
        p_min = {CoordMin, CoordMin, CoordMin};
        p_max = {CoordMax, CoordMax, CoordMax};
        for (int ph = 0; ph < NumPhases; ph++)
        begin
            case (ph)
                0: load_curve(p_max, p_max, p_max, p_max, PointWidth'(0));
                1: load_curve(p_min, p_min, p_min, p_min, PointWidth'(1));
                2: load_curve(p_min, p_max, p_min, p_max, PointWidth'(0));
                3: load_curve(p_max, p_min, p_max, p_min, PointWidth'(1));
                default: load_curve(rand_point(), rand_point(), rand_point(),
                                    rand_point(), PointWidth'({$urandom(), $urandom()}));
            endcase
            pace_idle = (ph != 5);
            for (int n = 0; n < PhaseItems; n++)
                send_t(rand_t());
            settle_pipe();
            pace_idle = 1'b1;
        end
    endtask

    // Back-pressure: hold the receiver off while the sender streams, so the
    // pipe fills and stalls its input; then let it drain.
    task automatic test_output_holdoff();
        load_curve(rand_point(), rand_point(), rand_point(), rand_point(), PointWidth'(0));
        pace_idle = 1'b0;
        sink_hold_req = 1'b1;
        wait (sink_holding);
        @(posedge clk);
        for (int n = 0; n < 40; n++)
            send_t(rand_t());
        settle_pipe();
        pace_idle = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int missing;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        params_ch.valid   = 1'b0;
        params_ch.t_param = '0;
        for (int i = 0; i < NumPoints; i++)
            ctrl_pt[i] = '0;
        quad_sel = 1'b1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_endpoints();
        test_unused_point();
        test_half_rounding();
        test_spare_index();
        test_random_curves();
        test_output_holdoff();

        settle_pipe();
        missing = pending_points.size();

        $display("Sent %0d t beats over %0d curve loads, both modes, %0d-cycle hold-off.",
                 beats_sent, curve_loads, SinkHoldCycles);
        $display("Checked %0d points: %0d mismatches, %0d unexpected, %0d missing.",
                 points_seen, mismatches, orphan_points, missing);
        if (mismatches == 0 && missing == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
